// File: design/scmd_pkg.sv
// shared types and constants of the set-1 scancode decoder with event queue
// no dependencies; imported by every module of the block
package scmd_pkg;

  // default queue depth, one slot stays free so capacity is depth minus one
  localparam int unsigned DEFAULT_QUEUE_DEPTH = 256;

  // event word layout
  localparam int unsigned EVENT_W     = 13;
  localparam int unsigned EV_PRESSED  = 7;
  localparam int unsigned EV_EXTENDED = 8;
  localparam int unsigned EV_SHIFT    = 9;
  localparam int unsigned EV_CTRL     = 10;
  localparam int unsigned EV_ALT      = 11;
  localparam int unsigned EV_CAPS     = 12;

  // scancode values
  localparam logic [7:0] PREFIX_BYTE = 8'hE0;
  localparam logic [6:0] LSHIFT_CODE = 7'h2A;
  localparam logic [6:0] RSHIFT_CODE = 7'h36;
  localparam logic [6:0] CTRL_CODE   = 7'h1D;
  localparam logic [6:0] ALT_CODE    = 7'h38;
  localparam logic [6:0] CAPS_CODE   = 7'h3A;

  // what the back end does with one transaction
  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_EVENT = 2'd1,
    CMD_POP   = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e            kind;
    logic [EVENT_W-1:0]   ev;
  } cmd_t;

endpackage

// File: design/scmd_front.sv
// front end: classifies each transaction and tracks prefix and modifier state
// depends on scmd_pkg
module scmd_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic          req_type_i,
  input  logic [7:0]    data_byte_i,
  input  logic          from_aux_i,
  output logic          cmd_valid_o,
  input  logic          cmd_stall_i,
  output scmd_pkg::cmd_t cmd_o
);
  import scmd_pkg::*;

  logic prefix_q, prefix_d;
  logic shift_q, shift_d;
  logic ctrl_q, ctrl_d;
  logic alt_q, alt_d;
  logic caps_q, caps_d;
  logic accept;
  logic released;
  logic [6:0] code;

  assign cmd_valid_o = in_valid_i;
  assign in_stall_o  = cmd_stall_i;
  assign accept      = in_valid_i && !cmd_stall_i;
  assign released    = data_byte_i[7];
  assign code        = data_byte_i[6:0];

  // decode and modifier update
  always_comb begin
    prefix_d = prefix_q;
    shift_d  = shift_q;
    ctrl_d   = ctrl_q;
    alt_d    = alt_q;
    caps_d   = caps_q;
    cmd_o.kind = CMD_NONE;
    if (req_type_i) begin
      cmd_o.kind = CMD_POP;
    end else if (!from_aux_i) begin
      if (data_byte_i == PREFIX_BYTE) begin
        prefix_d = 1'b1;
      end else begin
        cmd_o.kind = CMD_EVENT;
        prefix_d   = 1'b0;
        if (prefix_q) begin
          if (code == CTRL_CODE) begin
            ctrl_d = !released;
          end else if (code == ALT_CODE) begin
            alt_d = !released;
          end
        end else begin
          if (code == LSHIFT_CODE || code == RSHIFT_CODE) begin
            shift_d = !released;
          end else if (code == CTRL_CODE) begin
            ctrl_d = !released;
          end else if (code == ALT_CODE) begin
            alt_d = !released;
          end else if (code == CAPS_CODE && !released) begin
            caps_d = !caps_q;
          end
        end
      end
    end
    // snapshot taken after the update
    cmd_o.ev              = '0;
    cmd_o.ev[6:0]         = code;
    cmd_o.ev[EV_PRESSED]  = !released;
    cmd_o.ev[EV_EXTENDED] = prefix_q;
    cmd_o.ev[EV_SHIFT]    = shift_d;
    cmd_o.ev[EV_CTRL]     = ctrl_d;
    cmd_o.ev[EV_ALT]      = alt_d;
    cmd_o.ev[EV_CAPS]     = caps_d;
  end

  // state registers, updated on accepted transactions only
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q <= 1'b0;
      shift_q  <= 1'b0;
      ctrl_q   <= 1'b0;
      alt_q    <= 1'b0;
      caps_q   <= 1'b0;
    end else if (accept) begin
      prefix_q <= prefix_d;
      shift_q  <= shift_d;
      ctrl_q   <= ctrl_d;
      alt_q    <= alt_d;
      caps_q   <= caps_d;
    end
  end

endmodule

// File: design/scmd_cmdq.sv
// two-entry command queue between the front and back ends
// depends on scmd_pkg
module scmd_cmdq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_valid_i,
  output logic           wr_stall_o,
  input  scmd_pkg::cmd_t wr_cmd_i,
  output logic           rd_valid_o,
  input  logic           rd_stall_i,
  output scmd_pkg::cmd_t rd_cmd_o
);
  import scmd_pkg::*;

  cmd_t       slot_q [2];
  logic       head_q, head_d;
  logic       tail_q, tail_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;

  assign wr_stall_o = (count_q == 2'd2);
  assign rd_valid_o = (count_q != 2'd0);
  assign rd_cmd_o   = slot_q[head_q];
  assign push       = wr_valid_i && !wr_stall_o;
  assign pop        = rd_valid_o && !rd_stall_i;

  // pointer and count update
  always_comb begin
    head_d  = pop  ? !head_q : head_q;
    tail_d  = push ? !tail_q : tail_q;
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= 1'b0;
      tail_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  // payload slots
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[tail_q] <= wr_cmd_i;
    end
  end

endmodule

// File: design/scmd_back.sv
// back end: event ring buffer in a memory plus the registered result stage
// depends on scmd_pkg
module scmd_back #(
  parameter int unsigned QUEUE_DEPTH = scmd_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  output logic           cmd_stall_o,
  input  scmd_pkg::cmd_t cmd_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic           event_valid_o,
  output logic [6:0]     key_code_o,
  output logic           key_make_o,
  output logic           key_ext_o,
  output logic           shift_held_o,
  output logic           ctrl_held_o,
  output logic           alt_held_o,
  output logic           caps_on_o,
  output logic           queued_o,
  output logic           overflow_drop_o,
  output logic           queue_not_empty_o
);
  import scmd_pkg::*;

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [AW-1:0] LAST = AW'(QUEUE_DEPTH - 1);

  logic [EVENT_W-1:0] mem [QUEUE_DEPTH];
  logic [EVENT_W-1:0] rdata_q;
  logic [AW-1:0]      rd_q, rd_d, wr_q, wr_d, wr_next, rd_next;
  logic               out_valid_q;
  logic               ev_valid_q, ev_valid_d;
  logic               queued_q, queued_d;
  logic               drop_q, drop_d;
  logic               not_empty_q;
  logic               fire, empty, full, do_push, do_pop;

  // one transaction retires whenever the result slot is free or being taken
  assign fire        = cmd_valid_i && !(out_valid_q && out_stall_i);
  assign cmd_stall_o = out_valid_q && out_stall_i;

  assign wr_next = (wr_q == LAST) ? '0 : wr_q + 1'b1;
  assign rd_next = (rd_q == LAST) ? '0 : rd_q + 1'b1;
  assign empty   = (rd_q == wr_q);
  assign full    = (wr_next == rd_q);
  assign do_push = fire && (cmd_i.kind == CMD_EVENT) && !full;
  assign do_pop  = fire && (cmd_i.kind == CMD_POP) && !empty;

  // pointer and flag computation
  always_comb begin
    rd_d       = do_pop  ? rd_next : rd_q;
    wr_d       = do_push ? wr_next : wr_q;
    ev_valid_d = do_pop;
    queued_d   = do_push;
    drop_d     = (cmd_i.kind == CMD_EVENT) && full;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q        <= '0;
      wr_q        <= '0;
      out_valid_q <= 1'b0;
      ev_valid_q  <= 1'b0;
      queued_q    <= 1'b0;
      drop_q      <= 1'b0;
      not_empty_q <= 1'b0;
    end else if (fire) begin
      rd_q        <= rd_d;
      wr_q        <= wr_d;
      out_valid_q <= 1'b1;
      ev_valid_q  <= ev_valid_d;
      queued_q    <= queued_d;
      drop_q      <= drop_d;
      not_empty_q <= (rd_d != wr_d);
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // event memory, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_q] <= cmd_i.ev;
    end
    if (do_pop) begin
      rdata_q <= mem[rd_q];
    end
  end

  // event fields of the result, zero unless a pop returned an event
  assign out_valid_o       = out_valid_q;
  assign event_valid_o     = ev_valid_q;
  assign key_code_o        = ev_valid_q ? rdata_q[6:0] : 7'd0;
  assign key_make_o        = ev_valid_q && rdata_q[EV_PRESSED];
  assign key_ext_o         = ev_valid_q && rdata_q[EV_EXTENDED];
  assign shift_held_o      = ev_valid_q && rdata_q[EV_SHIFT];
  assign ctrl_held_o       = ev_valid_q && rdata_q[EV_CTRL];
  assign alt_held_o        = ev_valid_q && rdata_q[EV_ALT];
  assign caps_on_o         = ev_valid_q && rdata_q[EV_CAPS];
  assign queued_o          = queued_q;
  assign overflow_drop_o   = drop_q;
  assign queue_not_empty_o = not_empty_q;

endmodule

// File: design/scancode_modifier_decoder_fifo.sv
// set-1 scancode decoder with a queue of decoded key events
// each accepted transaction passes the command queue and then the registered result stage of the back end
// throughput: one transaction per cycle while the result side does not stall
// every transaction, byte or pop, yields exactly one result transaction
// reset clears pointers, prefix and modifier state at once; no clearing pass
// top level; depends on scmd_pkg, scmd_front, scmd_cmdq, scmd_back
module scancode_modifier_decoder_fifo #(
  parameter int unsigned QUEUE_DEPTH = scmd_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       req_type_i,
  input  logic [7:0] data_byte_i,
  input  logic       from_aux_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       event_valid_o,
  output logic [6:0] key_code_o,
  output logic       key_make_o,
  output logic       key_ext_o,
  output logic       shift_held_o,
  output logic       ctrl_held_o,
  output logic       alt_held_o,
  output logic       caps_on_o,
  output logic       queued_o,
  output logic       overflow_drop_o,
  output logic       queue_not_empty_o
);
  import scmd_pkg::*;

  cmd_t front_cmd, back_cmd;
  logic front_valid, front_stall;
  logic back_valid, back_stall;

  // decode
  scmd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .data_byte_i (data_byte_i),
    .from_aux_i  (from_aux_i),
    .cmd_valid_o (front_valid),
    .cmd_stall_i (front_stall),
    .cmd_o       (front_cmd)
  );

  // decoupling queue
  scmd_cmdq u_cmdq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (front_valid),
    .wr_stall_o (front_stall),
    .wr_cmd_i   (front_cmd),
    .rd_valid_o (back_valid),
    .rd_stall_i (back_stall),
    .rd_cmd_o   (back_cmd)
  );

  // event queue and results
  scmd_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_valid_i       (back_valid),
    .cmd_stall_o       (back_stall),
    .cmd_i             (back_cmd),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .event_valid_o     (event_valid_o),
    .key_code_o        (key_code_o),
    .key_make_o        (key_make_o),
    .key_ext_o         (key_ext_o),
    .shift_held_o      (shift_held_o),
    .ctrl_held_o       (ctrl_held_o),
    .alt_held_o        (alt_held_o),
    .caps_on_o         (caps_on_o),
    .queued_o          (queued_o),
    .overflow_drop_o   (overflow_drop_o),
    .queue_not_empty_o (queue_not_empty_o)
  );

endmodule

// File: sim/scmd_checker.sv
// checker for the set-1 scancode decoder: predicts every result from the accepted
// input transactions and compares each accepted result field by field
// depends on scmd_pkg; instantiated by tb_scancode_modifier_decoder_fifo
module scmd_checker #(
  parameter int unsigned QUEUE_DEPTH = scmd_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic       req_type_i,
  input  logic [7:0] data_byte_i,
  input  logic       from_aux_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic       event_valid_i,
  input  logic [6:0] key_code_i,
  input  logic       key_make_i,
  input  logic       key_ext_i,
  input  logic       shift_held_i,
  input  logic       ctrl_held_i,
  input  logic       alt_held_i,
  input  logic       caps_on_i,
  input  logic       queued_i,
  input  logic       overflow_drop_i,
  input  logic       queue_not_empty_i,
  output int         errors_o,
  output int         pending_o
);

  import scmd_pkg::*;

  localparam int unsigned RELEASE_BIT = 7;

  typedef struct packed {
    logic       caps;
    logic       alt;
    logic       ctrl;
    logic       shift;
    logic       extended;
    logic       pressed;
    logic [6:0] code;
  } key_event_t;

  typedef struct packed {
    logic       event_valid;
    logic [6:0] key_code;
    logic       key_make;
    logic       key_ext;
    logic       shift_held;
    logic       ctrl_held;
    logic       alt_held;
    logic       caps_on;
    logic       queued;
    logic       overflow_drop;
    logic       queue_not_empty;
  } key_result_t;

  // shadow copy of the decoder state
  key_event_t  stored_events[$];
  key_result_t expected_results[$];
  logic        prefix_armed;
  logic        shift_down;
  logic        ctrl_down;
  logic        alt_down;
  logic        caps_locked;
  int          mismatch_count;

  // decode one transaction against the shadow state
  function automatic key_result_t decode_transaction(input logic pop_req,
                                                      input logic [7:0] byte_val,
                                                      input logic aux);
    key_result_t res;
    key_event_t  key_ev;
    logic        released;
    logic        ext;
    logic [6:0]  code;
    res = '0;
    if (pop_req) begin
      if (stored_events.size() != 0) begin
        key_ev = stored_events.pop_front();
        res.event_valid = 1'b1;
        res.key_code    = key_ev.code;
        res.key_make    = key_ev.pressed;
        res.key_ext     = key_ev.extended;
        res.shift_held  = key_ev.shift;
        res.ctrl_held   = key_ev.ctrl;
        res.alt_held    = key_ev.alt;
        res.caps_on     = key_ev.caps;
      end
    end else if (!aux) begin
      if (byte_val == PREFIX_BYTE) begin
        prefix_armed = 1'b1;
      end else begin
        ext          = prefix_armed;
        prefix_armed = 1'b0;
        released     = byte_val[RELEASE_BIT];
        code         = byte_val[6:0];
        // ctrl and alt act with or without prefix, shift and caps only without
        if (code == CTRL_CODE) begin
          ctrl_down = !released;
        end else if (code == ALT_CODE) begin
          alt_down = !released;
        end else if (!ext) begin
          if (code == LSHIFT_CODE || code == RSHIFT_CODE) begin
            shift_down = !released;
          end else if (code == CAPS_CODE && !released) begin
            caps_locked = !caps_locked;
          end
        end
        key_ev.code     = code;
        key_ev.pressed  = !released;
        key_ev.extended = ext;
        key_ev.shift    = shift_down;
        key_ev.ctrl     = ctrl_down;
        key_ev.alt      = alt_down;
        key_ev.caps     = caps_locked;
        // one slot always stays free
        if (stored_events.size() >= QUEUE_DEPTH - 1) begin
          res.overflow_drop = 1'b1;
        end else begin
          stored_events.push_back(key_ev);
          res.queued = 1'b1;
        end
      end
    end
    res.queue_not_empty = (stored_events.size() != 0);
    return res;
  endfunction

  task automatic check_field(input string field, input int unsigned expected_v,
                             input int unsigned actual_v);
    if (expected_v != actual_v) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field,
               expected_v, actual_v);
    end
  endtask

  task automatic compare_result(input key_result_t exp_r);
    check_field("event_valid", 32'(exp_r.event_valid), 32'(event_valid_i));
    check_field("key_code", 32'(exp_r.key_code), 32'(key_code_i));
    check_field("key_make", 32'(exp_r.key_make), 32'(key_make_i));
    check_field("key_ext", 32'(exp_r.key_ext), 32'(key_ext_i));
    check_field("shift_held", 32'(exp_r.shift_held), 32'(shift_held_i));
    check_field("ctrl_held", 32'(exp_r.ctrl_held), 32'(ctrl_held_i));
    check_field("alt_held", 32'(exp_r.alt_held), 32'(alt_held_i));
    check_field("caps_on", 32'(exp_r.caps_on), 32'(caps_on_i));
    check_field("queued", 32'(exp_r.queued), 32'(queued_i));
    check_field("overflow_drop", 32'(exp_r.overflow_drop), 32'(overflow_drop_i));
    check_field("queue_not_empty", 32'(exp_r.queue_not_empty),
                32'(queue_not_empty_i));
  endtask

  // watch both channels; results are handled before the input of the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stored_events.delete();
      expected_results.delete();
      prefix_armed   = 1'b0;
      shift_down     = 1'b0;
      ctrl_down      = 1'b0;
      alt_down       = 1'b0;
      caps_locked    = 1'b0;
      mismatch_count = 0;
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result, expected nothing, actual key_code %0h",
                   $time, key_code_i);
        end else begin
          compare_result(expected_results.pop_front());
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_results.push_back(decode_transaction(req_type_i, data_byte_i,
                                                      from_aux_i));
      end
      errors_o  <= mismatch_count;
      pending_o <= expected_results.size();
    end
  end

endmodule

// File: sim/tb_scancode_modifier_decoder_fifo.sv
// testbench top for the set-1 scancode decoder with event queue: clock, reset,
// directed and random stimulus, random result stalls and the verdict
// depends on scmd_pkg, scancode_modifier_decoder_fifo and scmd_checker
module tb_scancode_modifier_decoder_fifo;

  import scmd_pkg::*;

  localparam int unsigned QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH;
  localparam logic        REQ_BYTE    = 1'b0;
  localparam logic        REQ_POP     = 1'b1;
  localparam int          CYCLE_LIMIT = 600000;
  localparam int          DRAIN_WAIT  = 10;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       req_type_i = REQ_BYTE;
  logic [7:0] data_byte_i = '0;
  logic       from_aux_i = 1'b0;
  logic       out_stall_i = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic       event_valid_o;
  logic [6:0] key_code_o;
  logic       key_make_o;
  logic       key_ext_o;
  logic       shift_held_o;
  logic       ctrl_held_o;
  logic       alt_held_o;
  logic       caps_on_o;
  logic       queued_o;
  logic       overflow_drop_o;
  logic       queue_not_empty_o;

  int         error_count;
  int         results_pending;
  int         cycle_count = 0;
  int         items_sent = 0;
  bit         no_gaps = 1'b0;

  // clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  scancode_modifier_decoder_fifo #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .req_type_i       (req_type_i),
    .data_byte_i      (data_byte_i),
    .from_aux_i       (from_aux_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .event_valid_o    (event_valid_o),
    .key_code_o       (key_code_o),
    .key_make_o       (key_make_o),
    .key_ext_o        (key_ext_o),
    .shift_held_o     (shift_held_o),
    .ctrl_held_o      (ctrl_held_o),
    .alt_held_o       (alt_held_o),
    .caps_on_o        (caps_on_o),
    .queued_o         (queued_o),
    .overflow_drop_o  (overflow_drop_o),
    .queue_not_empty_o(queue_not_empty_o)
  );

  scmd_checker #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .req_type_i       (req_type_i),
    .data_byte_i      (data_byte_i),
    .from_aux_i       (from_aux_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .event_valid_i    (event_valid_o),
    .key_code_i       (key_code_o),
    .key_make_i       (key_make_o),
    .key_ext_i        (key_ext_o),
    .shift_held_i     (shift_held_o),
    .ctrl_held_i      (ctrl_held_o),
    .alt_held_i       (alt_held_o),
    .caps_on_i        (caps_on_o),
    .queued_i         (queued_o),
    .overflow_drop_i  (overflow_drop_o),
    .queue_not_empty_i(queue_not_empty_o),
    .errors_o         (error_count),
    .pending_o        (results_pending)
  );

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // mostly short idle stretches, a few long ones
  function automatic int unsigned idle_length();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 88) return $urandom_range(1, 3);
    if (pick < 98) return $urandom_range(4, 10);
    return $urandom_range(15, 30);
  endfunction

  // result side stalls, with occasional long stall-free stretches
  initial begin
    int unsigned free_run;
    int unsigned stall_run;
    @(negedge clk_i);
    forever begin
      out_stall_i = 1'b0;
      if ($urandom_range(0, 19) == 0) free_run = $urandom_range(60, 150);
      else free_run = $urandom_range(1, 12);
      repeat (free_run) @(negedge clk_i);
      stall_run = idle_length();
      if (stall_run != 0) begin
        out_stall_i = 1'b1;
        repeat (stall_run) @(negedge clk_i);
      end
    end
  end

  // one input transaction; called and returns at a falling edge
  task automatic send(input logic req, input logic [7:0] byte_val, input logic aux);
    int unsigned gap;
    gap = no_gaps ? 0 : idle_length();
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    req_type_i  = req;
    data_byte_i = byte_val;
    from_aux_i  = aux;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    if (req == REQ_POP || !aux) items_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (results_pending != 0) @(negedge clk_i);
  endtask

  function automatic logic [6:0] modifier_code();
    case ($urandom_range(0, 4))
      0:       return LSHIFT_CODE;
      1:       return RSHIFT_CODE;
      2:       return CTRL_CODE;
      3:       return ALT_CODE;
      default: return CAPS_CODE;
    endcase
  endfunction

  // one key sequence, or a pop, or a byte of noise
  task automatic send_key_sequence(input int unsigned pop_pct);
    int unsigned pick;
    if ($urandom_range(0, 99) < pop_pct) begin
      send(REQ_POP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        send(REQ_BYTE, 8'($urandom_range(0, 255)), 1'b1);
      end else if (pick < 45) begin
        if ($urandom_range(0, 2) == 0) send(REQ_BYTE, PREFIX_BYTE, 1'b0);
        send(REQ_BYTE, {1'($urandom_range(0, 1)), modifier_code()}, 1'b0);
      end else if (pick < 65) begin
        send(REQ_BYTE, PREFIX_BYTE, 1'b0);
        send(REQ_BYTE, 8'($urandom_range(0, 255)), 1'b0);
      end else begin
        send(REQ_BYTE, 8'($urandom_range(0, 255)), 1'b0);
      end
    end
  endtask

  task automatic run_phase(input int unsigned count, input int unsigned pop_pct);
    int target;
    target = items_sent + count;
    while (items_sent < target) send_key_sequence(pop_pct);
  endtask

  // stimulus and verdict
  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: empty pop, prefixes, auxiliary bytes, modifiers, caps, odd codes
    send(REQ_POP, 8'hFF, 1'b1);
    send(REQ_BYTE, PREFIX_BYTE, 1'b0);
    send(REQ_BYTE, 8'h55, 1'b1);
    send(REQ_BYTE, {1'b0, CTRL_CODE}, 1'b0);
    send(REQ_BYTE, PREFIX_BYTE, 1'b0);
    send(REQ_BYTE, PREFIX_BYTE, 1'b0);
    send(REQ_BYTE, {1'b0, ALT_CODE}, 1'b0);
    send(REQ_BYTE, {1'b0, LSHIFT_CODE}, 1'b0);
    send(REQ_BYTE, {1'b1, RSHIFT_CODE}, 1'b0);
    send(REQ_BYTE, {1'b0, CAPS_CODE}, 1'b0);
    send(REQ_BYTE, {1'b1, CAPS_CODE}, 1'b0);
    send(REQ_BYTE, {1'b0, CAPS_CODE}, 1'b0);
    send(REQ_BYTE, PREFIX_BYTE, 1'b0);
    send(REQ_BYTE, {1'b0, LSHIFT_CODE}, 1'b0);
    send(REQ_BYTE, PREFIX_BYTE, 1'b0);
    send(REQ_BYTE, {1'b1, CTRL_CODE}, 1'b0);
    send(REQ_BYTE, {1'b1, ALT_CODE}, 1'b0);
    send(REQ_BYTE, 8'hE1, 1'b0);
    send(REQ_BYTE, 8'h00, 1'b0);
    send(REQ_BYTE, 8'hFF, 1'b0);
    send(REQ_BYTE, 8'h7F, 1'b0);
    send(REQ_BYTE, 8'h80, 1'b0);
    send(REQ_POP, 8'h00, 1'b0);
    send(REQ_POP, 8'hAA, 1'b1);
    send(REQ_POP, 8'h55, 1'b0);

    // mixed traffic, then hold off until the block has caught up
    run_phase(500, 40);
    wait_drained();

    // fill past capacity, half of it back to back
    run_phase(200, 3);
    no_gaps = 1'b1;
    run_phase(200, 3);
    no_gaps = 1'b0;

    // drain past empty
    run_phase(350, 90);
    wait_drained();

    run_phase(500, 50);

    // let the last results through
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (error_count == 0 && results_pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
